/* rtl/gds_pkg.sv */
package gds_pkg;

    localparam logic [2:0] FUNC_LOAD   = 3'd0;
    localparam logic [2:0] FUNC_DAYS   = 3'd1;
    localparam logic [2:0] FUNC_WEEKS  = 3'd2;
    localparam logic [2:0] FUNC_MONTHS = 3'd3;
    localparam logic [2:0] FUNC_YEARS  = 3'd4;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_SAT     = 2'd2;

    localparam logic [15:0] YEAR_MAX   = 16'd65535;
    localparam logic [15:0] YEAR_RESET = 16'd2000;
    localparam logic [3:0]  MONTH_JAN  = 4'd1;
    localparam logic [3:0]  MONTH_FEB  = 4'd2;
    localparam logic [3:0]  MONTH_DEC  = 4'd12;
    localparam logic [4:0]  DAY_FIRST  = 5'd1;
    localparam logic [4:0]  FEB_LEAP_LEN = 5'd29;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // multiplicative inverse of 25 modulo 2**16 and the largest quotient of a multiple
    localparam logic [15:0] INV25     = 16'd23593;
    localparam logic [15:0] DIV25_MAX = 16'd2621;

    typedef struct packed {
        logic [2:0]  func;
        logic [14:0] count;
        logic [4:0]  load_day;
        logic [3:0]  load_month;
        logic [15:0] load_year;
    } t_in_word;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
        logic [1:0]  status;
    } t_out_word;

    function automatic logic is_leap(input logic [15:0] year);
        logic [31:0] prod;
        logic        div25;
        prod  = {16'd0, year} * {16'd0, INV25};
        div25 = (prod[15:0] <= DIV25_MAX);
        return ((year[1:0] == 2'd0) && !div25) || ((year[3:0] == 4'd0) && div25);
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        if ((month < MONTH_JAN) || (month > MONTH_DEC)) begin
            len = 5'd0;
        end else if ((month == MONTH_FEB) && leap) begin
            len = FEB_LEAP_LEN;
        end else begin
            len = MONTH_LEN[4'(month - MONTH_JAN)];
        end
        return len;
    endfunction

endpackage

/* rtl/gregorian_date_stepper.sv */
// channel | valid   | stall   | word
// input   | i_valid | o_stall | i_word (gds_pkg::t_in_word)
// output  | o_valid | i_stall | o_word (gds_pkg::t_out_word)
// Load and year add go through their own state and ST_DONE to the result register;
// unused codes go straight to ST_DONE. Day add steps count days, week add 7 * count days, month add count months;
// one day or month step a cycle through the shared leap and month-length unit.
// o_stall is high from accept until the result enters the output register,
// including while a finished result waits for a stalled output register.
// A stalled result holds; the next word is taken while it waits.
// Synchronous active-low reset sets the date to 1 January 2000.
module gregorian_date_stepper (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  gds_pkg::t_in_word  i_word,
    output logic               o_valid,
    input  logic               i_stall,
    output gds_pkg::t_out_word o_word
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_DAYS   = 3'd2;
    localparam logic [2:0] ST_MONTHS = 3'd3;
    localparam logic [2:0] ST_YEARS  = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]         r_state,     n_state;
    logic [4:0]         r_cur_day,   n_cur_day;
    logic [3:0]         r_cur_month, n_cur_month;
    logic [15:0]        r_cur_year,  n_cur_year;
    gds_pkg::t_in_word  r_cmd,       n_cmd;
    logic [17:0]        r_cnt,       n_cnt;
    logic [1:0]         r_status,    n_status;
    gds_pkg::t_out_word r_out,       n_out;
    logic               r_out_valid, n_out_valid;

    logic [15:0] u_year;
    logic [3:0]  u_month;
    logic        u_leap;
    logic [4:0]  u_len;
    logic        w_last_month;
    logic [3:0]  w_next_month;
    logic [16:0] w_year_sum;
    logic        w_load_ok;

    assign w_last_month = (r_cur_month >= gds_pkg::MONTH_DEC);
    assign w_next_month = w_last_month ? gds_pkg::MONTH_JAN : 4'(r_cur_month + 4'd1);
    assign w_year_sum   = {1'b0, r_cur_year} + {2'b00, r_cmd.count};

    always_comb begin
        u_year = (r_state == ST_LOAD) ? r_cmd.load_year : r_cur_year;
        if (r_state == ST_LOAD) begin
            u_month = r_cmd.load_month;
        end else if (r_state == ST_MONTHS) begin
            u_month = w_next_month;
        end else begin
            u_month = r_cur_month;
        end
        u_leap = gds_pkg::is_leap(u_year);
        u_len  = gds_pkg::days_in(u_month, u_leap);
    end

    assign w_load_ok = (r_cmd.load_month >= gds_pkg::MONTH_JAN) &&
                       (r_cmd.load_month <= gds_pkg::MONTH_DEC) &&
                       (r_cmd.load_day >= gds_pkg::DAY_FIRST) &&
                       (r_cmd.load_day <= u_len);

    always_comb begin
        n_state     = r_state;
        n_cur_day   = r_cur_day;
        n_cur_month = r_cur_month;
        n_cur_year  = r_cur_year;
        n_cmd       = r_cmd;
        n_cnt       = r_cnt;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_cmd    = i_word;
                    n_status = gds_pkg::STATUS_OK;
                    n_cnt    = {3'b000, i_word.count};
                    unique case (i_word.func)
                        gds_pkg::FUNC_LOAD:   n_state = ST_LOAD;
                        gds_pkg::FUNC_DAYS:   n_state = ST_DAYS;
                        gds_pkg::FUNC_WEEKS: begin
                            n_cnt   = {i_word.count, 3'b000} - {3'b000, i_word.count};
                            n_state = ST_DAYS;
                        end
                        gds_pkg::FUNC_MONTHS: n_state = ST_MONTHS;
                        gds_pkg::FUNC_YEARS:  n_state = ST_YEARS;
                        default:              n_state = ST_DONE;
                    endcase
                end
            end
            ST_LOAD: begin
                if (w_load_ok) begin
                    n_cur_day   = r_cmd.load_day;
                    n_cur_month = r_cmd.load_month;
                    n_cur_year  = r_cmd.load_year;
                end else begin
                    n_status = gds_pkg::STATUS_INVALID;
                end
                n_state = ST_DONE;
            end
            ST_DAYS: begin
                if (r_cnt == 18'd0) begin
                    n_state = ST_DONE;
                end else if (r_cur_day >= u_len) begin
                    if (w_last_month && (r_cur_year == gds_pkg::YEAR_MAX)) begin
                        n_status = gds_pkg::STATUS_SAT;
                        n_state  = ST_DONE;
                    end else begin
                        if (w_last_month) begin
                            n_cur_year = 16'(r_cur_year + 16'd1);
                        end
                        n_cur_month = w_next_month;
                        n_cur_day   = gds_pkg::DAY_FIRST;
                        n_cnt       = 18'(r_cnt - 18'd1);
                    end
                end else begin
                    n_cur_day = 5'(r_cur_day + 5'd1);
                    n_cnt     = 18'(r_cnt - 18'd1);
                end
            end
            ST_MONTHS: begin
                if (r_cnt == 18'd0) begin
                    n_state = ST_DONE;
                end else if (w_last_month && (r_cur_year == gds_pkg::YEAR_MAX)) begin
                    n_status = gds_pkg::STATUS_SAT;
                    n_state  = ST_DONE;
                end else begin
                    if (w_last_month) begin
                        n_cur_year = 16'(r_cur_year + 16'd1);
                    end
                    n_cur_month = w_next_month;
                    if (r_cur_day > u_len) begin
                        n_cur_day = u_len;
                    end
                    n_cnt = 18'(r_cnt - 18'd1);
                end
            end
            ST_YEARS: begin
                if (w_year_sum[16]) begin
                    n_cur_year = gds_pkg::YEAR_MAX;
                    n_status   = gds_pkg::STATUS_SAT;
                end else begin
                    n_cur_year = w_year_sum[15:0];
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out.day    = r_cur_day;
                    n_out.month  = r_cur_month;
                    n_out.year   = r_cur_year;
                    n_out.status = r_status;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cur_day   <= gds_pkg::DAY_FIRST;
            r_cur_month <= gds_pkg::MONTH_JAN;
            r_cur_year  <= gds_pkg::YEAR_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cur_day   <= n_cur_day;
            r_cur_month <= n_cur_month;
            r_cur_year  <= n_cur_year;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_cnt    <= n_cnt;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_word  = r_out;

`ifndef SYNTHESIS
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_month >= gds_pkg::MONTH_JAN) && (r_cur_month <= gds_pkg::MONTH_DEC))
        else $error("held month out of range");

    a_day_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_day >= gds_pkg::DAY_FIRST) && (r_cur_day <= 5'd31))
        else $error("held day out of range");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state != ST_IDLE))
        else $error("accepted word did not start a command");

    a_sat_year: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_word.status == gds_pkg::STATUS_SAT)) |->
            (o_word.year == gds_pkg::YEAR_MAX))
        else $error("saturated status without maximum year");

    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && !(r_out_valid && i_stall)) |=> (o_valid && !o_stall))
        else $error("finished command did not present its result");
`endif

endmodule

/* dv/tb_gregorian_date_stepper.sv */
`timescale 1ns / 1ps

module tb_gregorian_date_stepper;

    localparam logic [2:0] FUNC_RSVD0 = 3'd5;
    localparam logic [2:0] FUNC_RSVD1 = 3'd6;
    localparam logic [2:0] FUNC_RSVD2 = 3'd7;
    localparam int unsigned N_RANDOM = 1300;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    gds_pkg::t_in_word  i_word = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    gds_pkg::t_out_word o_word;

    gds_pkg::t_in_word  pending_cmds[$];
    gds_pkg::t_out_word expected_dates[$];
    int unsigned n_total = 0;
    int unsigned n_accepted = 0;
    int unsigned n_checked = 0;
    int unsigned n_errors = 0;

    int unsigned cal_day = 1;
    int unsigned cal_month = 1;
    int unsigned cal_year = 2000;

    gregorian_date_stepper dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit leap_year(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_days(int unsigned m, int unsigned y);
        if (m < 1 || m > 12) begin
            return 0;
        end
        if (m == 2) begin
            return leap_year(y) ? 29 : 28;
        end
        return gds_pkg::MONTH_LEN[m - 1];
    endfunction

    function automatic bit next_day();
        if (cal_day >= month_days(cal_month, cal_year)) begin
            if (cal_month >= 12) begin
                if (cal_year >= gds_pkg::YEAR_MAX) begin
                    return 1'b0;
                end
                cal_year++;
                cal_month = 1;
            end else begin
                cal_month++;
            end
            cal_day = 1;
        end else begin
            cal_day++;
        end
        return 1'b1;
    endfunction

    function automatic bit next_month();
        int unsigned len;
        if (cal_month >= 12) begin
            if (cal_year >= gds_pkg::YEAR_MAX) begin
                return 1'b0;
            end
            cal_year++;
            cal_month = 1;
        end else begin
            cal_month++;
        end
        len = month_days(cal_month, cal_year);
        if (cal_day > len) begin
            cal_day = len;
        end
        return 1'b1;
    endfunction

    function automatic gds_pkg::t_out_word advance_calendar(gds_pkg::t_in_word w);
        gds_pkg::t_out_word r;
        int unsigned        steps;
        logic [1:0]         st;
        st = gds_pkg::STATUS_OK;
        case (w.func) inside
            gds_pkg::FUNC_LOAD: begin
                if (w.load_month >= 1 && w.load_month <= 12 && w.load_day >= 1 &&
                    w.load_day <= month_days(w.load_month, w.load_year)) begin
                    cal_day = w.load_day;
                    cal_month = w.load_month;
                    cal_year = w.load_year;
                end else begin
                    st = gds_pkg::STATUS_INVALID;
                end
            end
            gds_pkg::FUNC_DAYS, gds_pkg::FUNC_WEEKS: begin
                steps = (w.func == gds_pkg::FUNC_WEEKS) ? 7 * w.count : w.count;
                for (int unsigned i = 0; i < steps; i++) begin
                    if (!next_day()) begin
                        st = gds_pkg::STATUS_SAT;
                        break;
                    end
                end
            end
            gds_pkg::FUNC_MONTHS: begin
                for (int unsigned i = 0; i < w.count; i++) begin
                    if (!next_month()) begin
                        st = gds_pkg::STATUS_SAT;
                        break;
                    end
                end
            end
            gds_pkg::FUNC_YEARS: begin
                if (cal_year + w.count > gds_pkg::YEAR_MAX) begin
                    cal_year = gds_pkg::YEAR_MAX;
                    st = gds_pkg::STATUS_SAT;
                end else begin
                    cal_year += w.count;
                end
            end
            default: begin
            end
        endcase
        r.day = 5'(cal_day);
        r.month = 4'(cal_month);
        r.year = 16'(cal_year);
        r.status = st;
        return r;
    endfunction

    function automatic int unsigned gap_pct(int unsigned n);
        return (n >= 500 && n < 800) ? 0 : 14;
    endfunction

    task automatic push_cmd(logic [2:0] f, int unsigned c, int unsigned d, int unsigned m,
                            int unsigned y);
        gds_pkg::t_in_word w;
        w.func = f;
        w.count = 15'(c);
        w.load_day = 5'(d);
        w.load_month = 4'(m);
        w.load_year = 16'(y);
        pending_cmds.push_back(w);
        n_total++;
    endtask

    task automatic push_random_cmd();
        int unsigned pick;
        int unsigned c;
        int unsigned d;
        int unsigned m;
        int unsigned y;
        pick = $urandom_range(99);
        c = $urandom_range(32767);
        d = $urandom_range(31);
        m = $urandom_range(15);
        y = $urandom_range(65535);
        if (pick < 28) begin
            if ($urandom_range(99) < 80) begin
                case ($urandom_range(9)) inside
                    0, 1: y = 65535 - $urandom_range(3);
                    2: y = $urandom_range(20) * 100;
                    3: y = $urandom_range(5);
                    default: y = $urandom_range(65535);
                endcase
                m = $urandom_range(1, 12);
                d = $urandom_range(1, month_days(m, y));
            end
            push_cmd(gds_pkg::FUNC_LOAD, c, d, m, y);
        end else if (pick < 52) begin
            c = ($urandom_range(99) < 5) ? $urandom_range(2000) : $urandom_range(60);
            push_cmd(gds_pkg::FUNC_DAYS, c, d, m, y);
        end else if (pick < 64) begin
            c = ($urandom_range(99) < 5) ? $urandom_range(300) : $urandom_range(8);
            push_cmd(gds_pkg::FUNC_WEEKS, c, d, m, y);
        end else if (pick < 80) begin
            c = ($urandom_range(99) < 5) ? $urandom_range(1000) : $urandom_range(30);
            push_cmd(gds_pkg::FUNC_MONTHS, c, d, m, y);
        end else if (pick < 95) begin
            c = ($urandom_range(99) < 20) ? $urandom_range(32767) : $urandom_range(40);
            push_cmd(gds_pkg::FUNC_YEARS, c, d, m, y);
        end else begin
            push_cmd(3'(gds_pkg::FUNC_YEARS + $urandom_range(1, 3)), c, d, m, y);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_dates.push_back(advance_calendar(i_word));
                n_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= gap_pct(n_accepted)) begin
                    i_valid <= 1'b1;
                    i_word <= pending_cmds.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        gds_pkg::t_out_word want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_dates.size() == 0) begin
                    $error("unexpected result word: %0d/%0d/%0d status %0d",
                           o_word.day, o_word.month, o_word.year, o_word.status);
                    n_errors++;
                end else begin
                    want = expected_dates.pop_front();
                    n_checked++;
                    if (o_word.day !== want.day) begin
                        $error("day: expected %0d, got %0d", want.day, o_word.day);
                        n_errors++;
                    end
                    if (o_word.month !== want.month) begin
                        $error("month: expected %0d, got %0d", want.month, o_word.month);
                        n_errors++;
                    end
                    if (o_word.year !== want.year) begin
                        $error("year: expected %0d, got %0d", want.year, o_word.year);
                        n_errors++;
                    end
                    if (o_word.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_word.status);
                        n_errors++;
                    end
                end
            end
            i_stall <= ($urandom_range(99) < gap_pct(n_checked));
        end
    end

    initial begin
        push_cmd(gds_pkg::FUNC_DAYS, 0, 0, 0, 0);
        push_cmd(gds_pkg::FUNC_LOAD, 0, 29, 2, 2000);
        push_cmd(gds_pkg::FUNC_YEARS, 1, 0, 0, 0);
        push_cmd(gds_pkg::FUNC_DAYS, 1, 0, 0, 0);
        push_cmd(gds_pkg::FUNC_LOAD, 0, 29, 2, 1900);
        push_cmd(gds_pkg::FUNC_LOAD, 0, 0, 1, 2020);
        push_cmd(gds_pkg::FUNC_LOAD, 0, 31, 4, 2020);
        push_cmd(gds_pkg::FUNC_LOAD, 0, 1, 13, 2020);
        push_cmd(gds_pkg::FUNC_LOAD, 0, 1, 0, 2020);
        push_cmd(gds_pkg::FUNC_LOAD, 0, 31, 15, 65535);
        push_cmd(gds_pkg::FUNC_LOAD, 0, 31, 1, 2024);
        push_cmd(gds_pkg::FUNC_MONTHS, 1, 0, 0, 0);
        push_cmd(gds_pkg::FUNC_MONTHS, 12, 0, 0, 0);
        push_cmd(gds_pkg::FUNC_LOAD, 0, 31, 12, 1999);
        push_cmd(gds_pkg::FUNC_WEEKS, 0, 0, 0, 0);
        push_cmd(gds_pkg::FUNC_DAYS, 1, 0, 0, 0);
        push_cmd(FUNC_RSVD0, 32767, 31, 15, 65535);
        push_cmd(FUNC_RSVD1, 0, 0, 0, 0);
        push_cmd(FUNC_RSVD2, 12345, 17, 9, 4321);
        push_cmd(gds_pkg::FUNC_LOAD, 0, 31, 12, 65535);
        push_cmd(gds_pkg::FUNC_DAYS, 1, 0, 0, 0);
        push_cmd(gds_pkg::FUNC_WEEKS, 3, 0, 0, 0);
        push_cmd(gds_pkg::FUNC_LOAD, 0, 15, 11, 65535);
        push_cmd(gds_pkg::FUNC_MONTHS, 3, 0, 0, 0);
        push_cmd(gds_pkg::FUNC_LOAD, 0, 1, 1, 65000);
        push_cmd(gds_pkg::FUNC_YEARS, 535, 0, 0, 0);
        push_cmd(gds_pkg::FUNC_YEARS, 1, 0, 0, 0);
        push_cmd(gds_pkg::FUNC_LOAD, 0, 1, 1, 0);
        push_cmd(gds_pkg::FUNC_YEARS, 32767, 0, 0, 0);
        push_cmd(gds_pkg::FUNC_DAYS, 32767, 0, 0, 0);
        push_cmd(gds_pkg::FUNC_MONTHS, 32767, 0, 0, 0);
        push_cmd(gds_pkg::FUNC_WEEKS, 32767, 0, 0, 0);
        repeat (N_RANDOM) begin
            push_random_cmd();
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_accepted == n_total);
        wait (expected_dates.size() == 0);
        repeat (20) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/gds_pkg.sv
rtl/gregorian_date_stepper.sv
dv/tb_gregorian_date_stepper.sv
